// ===== hdl/dwt_pkg.sv =====
package dwt_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int POS_W       = 10;
	localparam int LEN_W       = 11;
	localparam int ORDER_W     = 2;
	localparam int COEF_W      = 18;
	localparam int PROD_W      = COEF_W + SAMPLE_W;
	localparam int ACC_W       = 36;
	localparam int TAP_W       = 4;
	localparam int BIT_W       = 4;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 11;
	localparam int MAX_LENGTH  = 1024;
	localparam int COEF_COUNT  = 28;
	localparam int COEF_ADDR_W = 5;

	localparam logic MODE_LOAD    = 1'b0;
	localparam logic MODE_COMPUTE = 1'b1;

	localparam logic [CFG_INDEX_W-1:0] REG_FILTER_ORDER  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SIGNAL_LENGTH = 2'd1;

	typedef struct packed {
		logic                       mode;
		logic [POS_W-1:0]           position;
		logic signed [SAMPLE_W-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] approximation;
		logic signed [ACC_W-1:0] detail;
		logic [POS_W-1:0]        at_position;
	} out_item_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} tap_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_STORE,
		ST_TAPS,
		ST_DRAIN
	} state_t;

	// Q2.16 scaling coefficients, rounded half away from zero.
	// D4 from 0, D6 from 4, D8 from 10, D10 from 18.
	localparam logic signed [COEF_W-1:0] COEF_TABLE [COEF_COUNT] = '{
		18'sd31651,  18'sd54822,  18'sd14689,  -18'sd8481,
		18'sd21802,  18'sd52880,  18'sd30139,  -18'sd8848,  -18'sd5599,  18'sd2309,
		18'sd15098,  18'sd46848,  18'sd41345,  -18'sd1834,  -18'sd12258, 18'sd2021,
		18'sd2155,   -18'sd695,
		18'sd10492,  18'sd39573,  18'sd47468,  18'sd9072,   -18'sd15879, -18'sd2113,
		18'sd5084,   -18'sd409,   -18'sd824,   18'sd219
	};

	localparam logic [COEF_ADDR_W-1:0] COEF_BASE [4] = '{5'd0, 5'd4, 5'd10, 5'd18};

	function automatic logic [TAP_W-1:0] tap_count(input logic [ORDER_W-1:0] order);
		return TAP_W'(4) + {1'b0, order, 1'b0};
	endfunction

	function automatic logic signed [COEF_W-1:0] coef_at(input logic [ORDER_W-1:0] order,
			input logic [TAP_W-1:0] tap);
		logic [COEF_ADDR_W-1:0] addr;
		addr = COEF_BASE[order] + COEF_ADDR_W'(tap);
		if (addr < COEF_ADDR_W'(COEF_COUNT)) begin
			return COEF_TABLE[addr];
		end
		return '0;
	endfunction

endpackage

// ===== hdl/daubechies_wavelet_filter_pair.sv =====
// Channel   | Signals                               | Transfer
// ----------+---------------------------------------+---------------------------------
// item in   | start, busy, item                     | edge with start high, busy low
// result    | result_valid, result                  | each cycle result_valid is high
// config    | cfg_valid, cfg_ready, cfg_index/_data | edge with cfg_valid and cfg_ready
//
// Every item first reduces its position modulo the signal length: restoring
// remainder, one position bit per cycle. A load then writes the store. A compute
// reads one tap per cycle through the single store read port into the shared
// MAC, then waits for the MAC to drain; busy stays high throughout. The result
// strobe is a single cycle, the last one with busy high; the receiver cannot
// stall. Config writes wait while busy. Reset clears control and the filter
// order and sets the signal length to the store depth; the sample store is not
// cleared.
module daubechies_wavelet_filter_pair (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  dwt_pkg::in_item_t                   item,
	output logic                                result_valid,
	output dwt_pkg::out_item_t                  result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dwt_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [dwt_pkg::CFG_DATA_W-1:0]      cfg_data
);

	// configuration
	logic [dwt_pkg::ORDER_W-1:0] order_q;
	logic [dwt_pkg::LEN_W-1:0]   length_q;
	logic [dwt_pkg::LEN_W-1:0]   len_eff;

	// sequencer
	dwt_pkg::state_t             state_q, state_d;
	logic                        accept;
	logic                        mod_step, store_en, tap_issue;
	logic [dwt_pkg::BIT_W-1:0]   bit_q;
	logic [dwt_pkg::TAP_W-1:0]   tap_q;
	logic [dwt_pkg::TAP_W-1:0]   taps;
	logic                        last_tap;
	logic                        tap_done;

	// datapath
	dwt_pkg::in_item_t           item_q;
	logic [dwt_pkg::POS_W-1:0]   rem_q;
	logic [dwt_pkg::POS_W-1:0]   rem_next;
	logic [dwt_pkg::LEN_W-1:0]   trial;
	logic [dwt_pkg::POS_W-1:0]   idx_q;
	logic [dwt_pkg::LEN_W-1:0]   idx_inc;
	logic [dwt_pkg::TAP_W-1:0]   mirror;
	logic signed [dwt_pkg::COEF_W-1:0] coef_mirror;

	logic signed [dwt_pkg::SAMPLE_W-1:0] store_q [dwt_pkg::MAX_LENGTH];
	logic signed [dwt_pkg::SAMPLE_W-1:0] sample_s1;
	logic signed [dwt_pkg::COEF_W-1:0]   coef_a_s1;
	logic signed [dwt_pkg::COEF_W-1:0]   coef_d_s1;
	dwt_pkg::tap_ctrl_t                  ctrl_s1;
	logic signed [dwt_pkg::ACC_W-1:0]    approx_sum;
	logic signed [dwt_pkg::ACC_W-1:0]    detail_sum;

	// Config writes are held off while an item is in flight.
	assign cfg_ready = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q  <= '0;
			length_q <= dwt_pkg::LEN_W'(dwt_pkg::MAX_LENGTH);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				dwt_pkg::REG_FILTER_ORDER:  order_q  <= cfg_data[dwt_pkg::ORDER_W-1:0];
				dwt_pkg::REG_SIGNAL_LENGTH: length_q <= cfg_data[dwt_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Zero length acts as one, oversize clamps to the store depth.
	always_comb begin
		if (length_q == '0) begin
			len_eff = dwt_pkg::LEN_W'(1);
		end else if (length_q > dwt_pkg::LEN_W'(dwt_pkg::MAX_LENGTH)) begin
			len_eff = dwt_pkg::LEN_W'(dwt_pkg::MAX_LENGTH);
		end else begin
			len_eff = length_q;
		end
	end

	assign busy   = (state_q != dwt_pkg::ST_IDLE);
	assign accept = start && !busy;

	assign taps     = dwt_pkg::tap_count(order_q);
	assign last_tap = (tap_q == taps - dwt_pkg::TAP_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dwt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mod_step  = 1'b0;
		store_en  = 1'b0;
		tap_issue = 1'b0;
		unique case (state_q)
			dwt_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = dwt_pkg::ST_MOD;
				end
			end
			dwt_pkg::ST_MOD: begin
				mod_step = 1'b1;
				if (bit_q == '0) begin
					state_d = (item_q.mode == dwt_pkg::MODE_LOAD) ? dwt_pkg::ST_STORE
					                                              : dwt_pkg::ST_TAPS;
				end
			end
			dwt_pkg::ST_STORE: begin
				store_en = 1'b1;
				state_d  = dwt_pkg::ST_IDLE;
			end
			dwt_pkg::ST_TAPS: begin
				tap_issue = 1'b1;
				if (last_tap) begin
					state_d = dwt_pkg::ST_DRAIN;
				end
			end
			dwt_pkg::ST_DRAIN: begin
				if (tap_done) begin
					state_d = dwt_pkg::ST_IDLE;
				end
			end
			default: state_d = dwt_pkg::ST_IDLE;
		endcase
	end

	// Restoring remainder step: shift in the next position bit, subtract if it fits.
	assign trial    = {rem_q, item_q.position[bit_q]};
	assign rem_next = (trial >= len_eff) ? dwt_pkg::POS_W'(trial - len_eff)
	                                     : trial[dwt_pkg::POS_W-1:0];

	// Circular index advance; idx is always below the length.
	assign idx_inc = {1'b0, idx_q} + dwt_pkg::LEN_W'(1);

	// Wavelet taps: reversed coefficients, odd taps negated.
	assign mirror      = taps - dwt_pkg::TAP_W'(1) - tap_q;
	assign coef_mirror = dwt_pkg::coef_at(order_q, mirror);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q   <= '0;
			tap_q   <= '0;
			ctrl_s1 <= '0;
		end else begin
			if (accept) begin
				bit_q <= dwt_pkg::BIT_W'(dwt_pkg::POS_W - 1);
				tap_q <= '0;
			end else begin
				if (mod_step) begin
					bit_q <= bit_q - dwt_pkg::BIT_W'(1);
				end
				if (tap_issue) begin
					tap_q <= tap_q + dwt_pkg::TAP_W'(1);
				end
			end
			ctrl_s1.valid <= tap_issue;
			ctrl_s1.first <= tap_issue && (tap_q == '0);
			ctrl_s1.last  <= tap_issue && last_tap;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
			rem_q  <= '0;
		end
		if (mod_step) begin
			rem_q <= rem_next;
			idx_q <= rem_next;
		end
		if (tap_issue) begin
			idx_q     <= (idx_inc == len_eff) ? '0 : idx_inc[dwt_pkg::POS_W-1:0];
			coef_a_s1 <= dwt_pkg::coef_at(order_q, tap_q);
			coef_d_s1 <= tap_q[0] ? -coef_mirror : coef_mirror;
		end
	end

	// Sample store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (store_en) begin
			store_q[rem_q] <= item_q.sample;
		end
		sample_s1 <= store_q[idx_q];
	end

	dwt_tap_unit u_tap (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl_s1   (ctrl_s1),
		.sample_s1 (sample_s1),
		.coef_a_s1 (coef_a_s1),
		.coef_d_s1 (coef_d_s1),
		.approx    (approx_sum),
		.detail    (detail_sum),
		.done      (tap_done)
	);

	// Accumulators hold until the next compute starts; the item register holds until the next item is accepted.
	assign result_valid         = tap_done;
	assign result.approximation = approx_sum;
	assign result.detail        = detail_sum;
	assign result.at_position   = item_q.position;

endmodule

// ===== hdl/dwt_tap_unit.sv =====
// Shared multiply-accumulate for both filter branches: product stage, then accumulate.
module dwt_tap_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dwt_pkg::tap_ctrl_t                  ctrl_s1,
	input  logic signed [dwt_pkg::SAMPLE_W-1:0] sample_s1,
	input  logic signed [dwt_pkg::COEF_W-1:0]   coef_a_s1,
	input  logic signed [dwt_pkg::COEF_W-1:0]   coef_d_s1,
	output logic signed [dwt_pkg::ACC_W-1:0]    approx,
	output logic signed [dwt_pkg::ACC_W-1:0]    detail,
	output logic                                done
);

	localparam int EXT_W = dwt_pkg::ACC_W - dwt_pkg::PROD_W;

	dwt_pkg::tap_ctrl_t                 ctrl_s2;
	logic signed [dwt_pkg::PROD_W-1:0]  prod_a_s2;
	logic signed [dwt_pkg::PROD_W-1:0]  prod_d_s2;
	logic signed [dwt_pkg::ACC_W-1:0]   acc_a_q;
	logic signed [dwt_pkg::ACC_W-1:0]   acc_d_q;
	logic                               done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
			done_q  <= 1'b0;
		end else begin
			ctrl_s2 <= ctrl_s1;
			done_q  <= ctrl_s2.valid && ctrl_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_s1.valid) begin
			prod_a_s2 <= coef_a_s1 * sample_s1;
			prod_d_s2 <= coef_d_s1 * sample_s1;
		end
		if (ctrl_s2.valid) begin
			acc_a_q <= (ctrl_s2.first ? '0 : acc_a_q) + {{EXT_W{prod_a_s2[dwt_pkg::PROD_W-1]}}, prod_a_s2};
			acc_d_q <= (ctrl_s2.first ? '0 : acc_d_q) + {{EXT_W{prod_d_s2[dwt_pkg::PROD_W-1]}}, prod_d_s2};
		end
	end

	assign approx = acc_a_q;
	assign detail = acc_d_q;
	assign done   = done_q;

endmodule

// ===== hdl/dwt_checker.sv =====
module dwt_checker (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input dwt_pkg::in_item_t       item,
	input logic                    result_valid
);

	// Any accepted item keeps the block busy on the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy low after an accepted item");

	// A result marks the last cycle of a busy period.
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy ##1 !busy)
		else $error("result outside the end of a compute");

	// At most one result per compute, never on consecutive cycles.
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe held for two cycles");

	// A load leaves no result behind: its busy period ends quietly.
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (item.mode == dwt_pkg::MODE_LOAD) |=> ##10 !result_valid)
		else $error("result after a load");

endmodule

bind daubechies_wavelet_filter_pair dwt_checker u_dwt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.item         (item),
	.result_valid (result_valid)
);
